// ----- rtl/tws_pkg.sv -----
// shared constants, types and codes for the timing wheel scheduler
`default_nettype none
package tws_pkg;
    localparam int SLOTS    = 64;   // power of two
    localparam int TICK_DIV = 1;    // power of two
    localparam int TIMERS   = 32;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int TICK_SH = $clog2(TICK_DIV);
    localparam int IDX_W   = $clog2(TIMERS);
    localparam int PTR_W   = $clog2(TIMERS + 1);
    localparam int TIME_W  = 20;
    localparam int ID_W    = 5;
    localparam int TAG_W   = 16;
    localparam int ROT_W   = 13;
    localparam int ACT_W   = 2;
    localparam int KIND_W  = 3;

    localparam logic [PTR_W-1:0] NONE    = PTR_W'(TIMERS);
    localparam logic [ROT_W-1:0] ROT_MAX = {ROT_W{1'b1}};

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD  = 2'd0,
        ACT_DEL  = 2'd1,
        ACT_TICK = 2'd2,
        ACT_NOP  = 2'd3
    } t_action;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED    = 3'd0,
        KIND_ADD_NEG  = 3'd1,
        KIND_ADD_FULL = 3'd2,
        KIND_DELETED  = 3'd3,
        KIND_DEL_BAD  = 3'd4,
        KIND_EXPIRED  = 3'd5,
        KIND_TICKED   = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_NEG,
        OP_DEL,
        OP_TICK
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] tslot;
        logic [ROT_W-1:0]  rot;
        logic [TAG_W-1:0]  tag;
        logic [ID_W-1:0]   id;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD0,
        S_ADD1,
        S_ADD2,
        S_DEL0,
        S_DEL1,
        S_TICK0,
        S_TICK1,
        S_WALK,
        S_EMIT
    } t_state;
endpackage
`default_nettype wire

// ----- rtl/timing_wheel_scheduler_core.sv -----
// hashed timing wheel scheduler top level
// channel  direction  handshake          payload
// request  in         i_valid / o_stall  i_action i_timeout i_timer_id i_user_tag
// result   out        o_valid / i_stall  o_kind o_timer_id_res o_user_tag_res
//                                        o_slot_index o_rotation o_last
// add: states ADD0, ADD1, ADD2; delete: DEL0, DEL1; tick: TICK0, TICK1, then a walk
// over the slot list that visits each timer in it, bounded by the timer pool size
// reset is synchronous and active low; slot heads read as empty after it at once
// a two-entry queue lets requests be taken while the engine is busy
// a stalled result holds the engine in its emitting step
`default_nettype none
module timing_wheel_scheduler_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [tws_pkg::ACT_W-1:0]         i_action,
    input  wire logic signed [tws_pkg::TIME_W-1:0] i_timeout,
    input  wire logic [tws_pkg::ID_W-1:0]          i_timer_id,
    input  wire logic [tws_pkg::TAG_W-1:0]         i_user_tag,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [tws_pkg::KIND_W-1:0]             o_kind,
    output logic [tws_pkg::ID_W-1:0]               o_timer_id_res,
    output logic [tws_pkg::TAG_W-1:0]              o_user_tag_res,
    output logic [tws_pkg::SLOT_W-1:0]             o_slot_index,
    output logic [tws_pkg::ROT_W-1:0]              o_rotation,
    output logic                                   o_last
);
    import tws_pkg::*;

    logic q_full, push, pop, q_valid;
    t_cmd f_cmd, q_cmd;

    tws_front u_front (
        .i_valid    (i_valid),
        .i_action   (i_action),
        .i_timeout  (i_timeout),
        .i_timer_id (i_timer_id),
        .i_user_tag (i_user_tag),
        .i_q_full   (q_full),
        .o_stall    (o_stall),
        .o_push     (push),
        .o_cmd      (f_cmd)
    );

    tws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    tws_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_cmd          (q_cmd),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_timer_id_res (o_timer_id_res),
        .o_user_tag_res (o_user_tag_res),
        .o_slot_index   (o_slot_index),
        .o_rotation     (o_rotation),
        .o_last         (o_last)
    );
endmodule
`default_nettype wire

// ----- rtl/tws_front.sv -----
// front end: classifies requests and turns a timeout into slot offset and rotation
`default_nettype none
module tws_front (
    input  wire logic                      i_valid,
    input  wire logic [tws_pkg::ACT_W-1:0] i_action,
    input  wire logic signed [tws_pkg::TIME_W-1:0] i_timeout,
    input  wire logic [tws_pkg::ID_W-1:0]  i_timer_id,
    input  wire logic [tws_pkg::TAG_W-1:0] i_user_tag,
    input  wire logic                      i_q_full,
    output logic                           o_stall,
    output logic                           o_push,
    output tws_pkg::t_cmd                  o_cmd
);
    import tws_pkg::*;

    localparam int SH_W = TIME_W - TICK_SH - SLOT_W;

    logic [TIME_W-1:0] ticks;
    logic [SH_W-1:0]   rot_full;
    t_action           act;

    assign act = t_action'(i_action);

    always_comb begin
        if (i_timeout == '0) begin
            ticks = TIME_W'(1);
        end else begin
            ticks = TIME_W'($unsigned(i_timeout) >> TICK_SH);
        end
        rot_full = ticks[TIME_W-1-TICK_SH:SLOT_W];
    end

    always_comb begin
        o_cmd.tslot = ticks[SLOT_W-1:0];
        if (32'(rot_full) > 32'(ROT_MAX)) begin
            o_cmd.rot = ROT_MAX;
        end else begin
            o_cmd.rot = ROT_W'(rot_full);
        end
        o_cmd.tag = i_user_tag;
        o_cmd.id  = i_timer_id;
        case (act)
            ACT_ADD:  o_cmd.op = i_timeout[TIME_W-1] ? OP_NEG : OP_ADD;
            ACT_DEL:  o_cmd.op = OP_DEL;
            default:  o_cmd.op = OP_TICK;
        endcase
    end

    assign o_stall = i_q_full;
    // unused action code makes no item for the back end
    assign o_push  = i_valid && !i_q_full && (act != ACT_NOP);
endmodule
`default_nettype wire

// ----- rtl/tws_queue.sv -----
// two-entry command queue between front and back end
`default_nettype none
module tws_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tws_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output tws_pkg::t_cmd      o_cmd
);
    import tws_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end
endmodule
`default_nettype wire

// ----- rtl/tws_back.sv -----
// back end: timer pool, slot heads, list maintenance and result register
`default_nettype none
module tws_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_q_valid,
    input  wire tws_pkg::t_cmd              i_cmd,
    output logic                            o_pop,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [tws_pkg::KIND_W-1:0]      o_kind,
    output logic [tws_pkg::ID_W-1:0]        o_timer_id_res,
    output logic [tws_pkg::TAG_W-1:0]       o_user_tag_res,
    output logic [tws_pkg::SLOT_W-1:0]      o_slot_index,
    output logic [tws_pkg::ROT_W-1:0]       o_rotation,
    output logic                            o_last
);
    import tws_pkg::*;

    // timer pool
    logic              r_valid [TIMERS];
    logic [ROT_W-1:0]  r_rot   [TIMERS];
    logic [SLOT_W-1:0] r_eslot [TIMERS];
    logic [TAG_W-1:0]  r_tag   [TIMERS];
    logic [PTR_W-1:0]  r_next  [TIMERS];
    logic [PTR_W-1:0]  r_prev  [TIMERS];

    // slot heads: memory plus per-slot written bits
    logic [PTR_W-1:0]  r_hmem [SLOTS];
    logic              r_hv   [SLOTS];
    logic [PTR_W-1:0]  r_hq;
    logic              r_hqv;

    t_state            r_state, n_state;
    t_cmd              r_cmd;
    logic [SLOT_W-1:0] r_cur, r_slot;
    logic [IDX_W-1:0]  r_id;
    logic [PTR_W-1:0]  r_nx, r_pv, r_hd, r_walk, r_thead, r_steps;
    t_kind             r_ekind;
    logic [ID_W-1:0]   r_eid;

    logic              r_ov, r_olast;
    t_kind             r_okind;
    logic [ID_W-1:0]   r_oid;
    logic [TAG_W-1:0]  r_otag;
    logic [SLOT_W-1:0] r_oslot;
    logic [ROT_W-1:0]  r_orot;

    logic              out_free, free_found, del_bad, walk_live;
    logic [IDX_W-1:0]  free_id, rd_idx, walk_idx;
    logic [PTR_W-1:0]  head, e_next, e_prev;
    logic [ROT_W-1:0]  e_rot;
    logic [TAG_W-1:0]  e_tag;
    logic [SLOT_W-1:0] e_slot;

    // datapath controls
    logic              emit;
    t_kind             em_kind;
    logic [ID_W-1:0]   em_id;
    logic [TAG_W-1:0]  em_tag;
    logic [SLOT_W-1:0] em_slot;
    logic [ROT_W-1:0]  em_rot;
    logic              em_last;
    logic              hm_re, hm_we;
    logic [SLOT_W-1:0] hm_ra, hm_wa;
    logic [PTR_W-1:0]  hm_wd;
    logic              add_we, clr_we, rot_we, nxt_we, prv_we;
    logic [IDX_W-1:0]  add_a, clr_a, rot_a, nxt_a, prv_a;
    logic [ROT_W-1:0]  rot_d;
    logic [PTR_W-1:0]  nxt_d, prv_d;
    logic              walk_adv;

    assign out_free = !r_ov || !i_stall;
    assign head     = r_hqv ? r_hq : NONE;
    assign walk_idx = r_walk[IDX_W-1:0];
    assign rd_idx   = (r_state == S_WALK) ? walk_idx : r_cmd.id[IDX_W-1:0];
    assign e_next   = r_next[rd_idx];
    assign e_prev   = r_prev[rd_idx];
    assign e_rot    = r_rot[rd_idx];
    assign e_tag    = r_tag[rd_idx];
    assign e_slot   = r_eslot[rd_idx];
    assign del_bad  = (PTR_W'(r_cmd.id) >= NONE) || !r_valid[rd_idx];
    assign walk_live = (r_walk < NONE) && r_valid[walk_idx] && (r_steps < NONE);
    assign o_pop    = (r_state == S_IDLE) && i_q_valid;

    // lowest free entry
    always_comb begin
        free_found = 1'b0;
        free_id    = '0;
        for (int i = TIMERS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_id    = IDX_W'(i);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_cmd.op)
                        OP_ADD:  n_state = S_ADD0;
                        OP_NEG:  n_state = S_EMIT;
                        OP_DEL:  n_state = S_DEL0;
                        default: n_state = S_TICK0;
                    endcase
                end
            end
            S_ADD0:  n_state = free_found ? S_ADD1 : S_EMIT;
            S_ADD1:  n_state = S_ADD2;
            S_ADD2:  n_state = out_free ? S_IDLE : S_ADD2;
            S_DEL0:  n_state = del_bad ? S_EMIT : S_DEL1;
            S_DEL1:  n_state = out_free ? S_IDLE : S_DEL1;
            S_TICK0: n_state = S_TICK1;
            S_TICK1: n_state = S_WALK;
            S_WALK:  n_state = (!walk_live && out_free) ? S_IDLE : S_WALK;
            S_EMIT:  n_state = out_free ? S_IDLE : S_EMIT;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath actions
    always_comb begin
        emit = 1'b0; em_kind = KIND_TICKED; em_id = '0; em_tag = '0;
        em_slot = '0; em_rot = '0; em_last = 1'b1;
        hm_re = 1'b0; hm_ra = '0; hm_we = 1'b0; hm_wa = '0; hm_wd = '0;
        add_we = 1'b0; add_a = r_id;
        clr_we = 1'b0; clr_a = rd_idx;
        rot_we = 1'b0; rot_a = walk_idx; rot_d = e_rot - ROT_W'(1);
        nxt_we = 1'b0; nxt_a = '0; nxt_d = '0;
        prv_we = 1'b0; prv_a = '0; prv_d = '0;
        walk_adv = 1'b0;
        case (r_state)
            S_ADD0: begin
                hm_re = 1'b1;
                hm_ra = r_cur + r_cmd.tslot;
            end
            S_ADD1: begin
                add_we = 1'b1;
                hm_we  = 1'b1;
                hm_wa  = r_slot;
                hm_wd  = PTR_W'(r_id);
            end
            S_ADD2: begin
                if (out_free) begin
                    emit    = 1'b1;
                    em_kind = KIND_ADDED;
                    em_id   = ID_W'(r_id);
                    em_slot = r_slot;
                    em_rot  = r_cmd.rot;
                    if (r_hd < NONE) begin
                        prv_we = 1'b1;
                        prv_a  = r_hd[IDX_W-1:0];
                        prv_d  = PTR_W'(r_id);
                    end
                end
            end
            S_DEL0: begin
                hm_re = 1'b1;
                hm_ra = e_slot;
            end
            S_DEL1: begin
                if (out_free) begin
                    emit    = 1'b1;
                    em_kind = KIND_DELETED;
                    em_id   = r_cmd.id;
                    clr_we  = 1'b1;
                    clr_a   = r_id;
                    if (head == PTR_W'(r_id)) begin
                        hm_we = 1'b1; hm_wa = r_slot; hm_wd = r_nx;
                    end else if (r_pv < NONE) begin
                        nxt_we = 1'b1; nxt_a = r_pv[IDX_W-1:0]; nxt_d = r_nx;
                    end
                    if (r_nx < NONE) begin
                        prv_we = 1'b1; prv_a = r_nx[IDX_W-1:0]; prv_d = r_pv;
                    end
                end
            end
            S_TICK0: begin
                hm_re = 1'b1;
                hm_ra = r_cur;
            end
            S_WALK: begin
                if (walk_live) begin
                    if (e_rot != '0) begin
                        rot_we   = 1'b1;
                        walk_adv = 1'b1;
                    end else if (out_free) begin
                        // expire and unlink in the same cycle
                        emit     = 1'b1;
                        em_kind  = KIND_EXPIRED;
                        em_id    = ID_W'(walk_idx);
                        em_tag   = e_tag;
                        em_slot  = r_cur;
                        em_last  = 1'b0;
                        walk_adv = 1'b1;
                        clr_we   = 1'b1;
                        if (r_thead == r_walk) begin
                            hm_we = 1'b1; hm_wa = r_cur; hm_wd = e_next;
                        end else if (e_prev < NONE) begin
                            nxt_we = 1'b1; nxt_a = e_prev[IDX_W-1:0]; nxt_d = e_next;
                        end
                        if (e_next < NONE) begin
                            prv_we = 1'b1; prv_a = e_next[IDX_W-1:0]; prv_d = e_prev;
                        end
                    end
                end else if (out_free) begin
                    emit    = 1'b1;
                    em_kind = KIND_TICKED;
                    em_slot = r_cur;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    em_kind = r_ekind;
                    em_id   = r_eid;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur   <= '0;
            r_ov    <= 1'b0;
            for (int i = 0; i < TIMERS; i++) r_valid[i] <= 1'b0;
            for (int s = 0; s < SLOTS; s++) r_hv[s] <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            if (add_we) r_valid[add_a] <= 1'b1;
            if (clr_we) r_valid[clr_a] <= 1'b0;
            if (hm_we)  r_hv[hm_wa] <= 1'b1;
            if (r_state == S_WALK && !walk_live && out_free) begin
                r_cur <= (r_cur == SLOT_W'(SLOTS - 1)) ? '0 : r_cur + SLOT_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) r_cmd <= i_cmd;
        if (r_state == S_IDLE && i_q_valid) begin
            r_ekind <= KIND_ADD_NEG;
            r_eid   <= '0;
        end
        if (r_state == S_ADD0) begin
            r_id    <= free_id;
            r_slot  <= hm_ra;
            r_ekind <= KIND_ADD_FULL;
        end
        if (r_state == S_ADD1) r_hd <= head;
        if (r_state == S_DEL0) begin
            r_id    <= rd_idx;
            r_slot  <= e_slot;
            r_nx    <= e_next;
            r_pv    <= e_prev;
            r_ekind <= KIND_DEL_BAD;
            r_eid   <= r_cmd.id;
        end
        if (r_state == S_TICK1) begin
            r_walk  <= head;
            r_thead <= head;
            r_steps <= '0;
        end
        if (walk_adv) begin
            r_walk  <= e_next;
            r_steps <= r_steps + PTR_W'(1);
            if (r_thead == r_walk && e_rot == '0) r_thead <= e_next;
        end
        if (add_we) begin
            r_rot[add_a]   <= r_cmd.rot;
            r_eslot[add_a] <= r_slot;
            r_tag[add_a]   <= r_cmd.tag;
            r_next[add_a]  <= head;
        end
        if (rot_we) r_rot[rot_a] <= rot_d;
        if (nxt_we) r_next[nxt_a] <= nxt_d;
        if (add_we) begin
            r_prev[add_a] <= NONE;
        end else if (prv_we) begin
            r_prev[prv_a] <= prv_d;
        end
        if (emit) begin
            r_okind <= em_kind;
            r_oid   <= em_id;
            r_otag  <= em_tag;
            r_oslot <= em_slot;
            r_orot  <= em_rot;
            r_olast <= em_last;
        end
    end

    // slot head memory
    always_ff @(posedge i_clk) begin
        if (hm_we) r_hmem[hm_wa] <= hm_wd;
        if (hm_re) begin
            r_hq  <= r_hmem[hm_ra];
            r_hqv <= r_hv[hm_ra];
        end
    end

    assign o_valid        = r_ov;
    assign o_kind         = r_okind;
    assign o_timer_id_res = r_oid;
    assign o_user_tag_res = r_otag;
    assign o_slot_index   = r_oslot;
    assign o_rotation     = r_orot;
    assign o_last         = r_olast;

`ifndef SYNTHESIS
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_steps <= NONE))
        else $error("tick walk ran past the pool size");
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && em_kind != KIND_EXPIRED) |-> em_last)
        else $error("single result without last flag");
    a_expire_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && em_kind == KIND_EXPIRED) |-> (r_state == S_WALK && !em_last))
        else $error("expiry outside a tick walk");
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_q_valid) |=> (r_state == S_IDLE))
        else $error("engine left idle without a command");
`endif
endmodule
`default_nettype wire

// ----- sim/tb_timing_wheel_scheduler_core.sv -----
// self-checking testbench for the timing wheel scheduler core
`default_nettype none
module tb_timing_wheel_scheduler_core;
    timeunit 1ns;
    timeprecision 1ps;
    import tws_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [TAG_W-1:0]  tag;
        logic [SLOT_W-1:0] slot;
        logic [ROT_W-1:0]  rot;
        logic              last;
    } t_res;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall_out;
    logic [ACT_W-1:0]         act = '0;
    logic signed [TIME_W-1:0] tmo = '0;
    logic [ID_W-1:0]          tid = '0;
    logic [TAG_W-1:0]         utag = '0;
    logic                     res_valid;
    logic                     res_stall = 1'b0;
    logic [KIND_W-1:0]        o_kind;
    logic [ID_W-1:0]          o_id;
    logic [TAG_W-1:0]         o_tag;
    logic [SLOT_W-1:0]        o_slot;
    logic [ROT_W-1:0]         o_rot;
    logic                     o_last;

    timing_wheel_scheduler_core i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall_out),
        .i_action(act), .i_timeout(tmo), .i_timer_id(tid), .i_user_tag(utag),
        .o_valid(res_valid), .i_stall(res_stall), .o_kind(o_kind),
        .o_timer_id_res(o_id), .o_user_tag_res(o_tag), .o_slot_index(o_slot),
        .o_rotation(o_rot), .o_last(o_last)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predicted wheel state
    logic             w_valid [TIMERS];
    logic [ROT_W-1:0] w_rot   [TIMERS];
    int               w_slot  [TIMERS];
    logic [TAG_W-1:0] w_tag   [TIMERS];
    int               w_next  [TIMERS];
    int               w_prev  [TIMERS];
    int               w_head  [SLOTS];
    int               w_cur;

    t_res expected_results[$];
    int   errors = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   hold_cycles = 0;

    function automatic t_res mk(logic [KIND_W-1:0] k, int id, logic [TAG_W-1:0] tg,
                                int sl, int rt, logic l);
        t_res r;
        r.kind = k; r.id = ID_W'(id); r.tag = tg; r.slot = SLOT_W'(sl);
        r.rot = ROT_W'(rt); r.last = l;
        return r;
    endfunction

    function automatic void wheel_clear();
        for (int i = 0; i < TIMERS; i++) w_valid[i] = 1'b0;
        for (int s = 0; s < SLOTS; s++) w_head[s] = TIMERS;
        w_cur = 0;
    endfunction

    function automatic void wheel_unlink(int id);
        int s;
        s = w_slot[id];
        if (w_head[s] == id) w_head[s] = w_next[id];
        else if (w_prev[id] < TIMERS) w_next[w_prev[id]] = w_next[id];
        if (w_next[id] < TIMERS) w_prev[w_next[id]] = w_prev[id];
        w_valid[id] = 1'b0;
    endfunction

    function automatic void wheel_predict(logic [ACT_W-1:0] a, logic [TIME_W-1:0] t,
                                          logic [ID_W-1:0] id_in, logic [TAG_W-1:0] tg);
        int id, ticks, rt, sl, cur, nx, steps, s;
        if (a == ACT_ADD) begin
            if (t[TIME_W-1]) begin
                expected_results.push_back(mk(KIND_ADD_NEG, 0, 0, 0, 0, 1'b1));
                return;
            end
            id = TIMERS;
            for (int i = TIMERS - 1; i >= 0; i--) if (!w_valid[i]) id = i;
            if (id == TIMERS) begin
                expected_results.push_back(mk(KIND_ADD_FULL, 0, 0, 0, 0, 1'b1));
                return;
            end
            ticks = (t == 0) ? 1 : int'(t) / TICK_DIV;
            rt = ticks / SLOTS;
            if (rt > 8191) rt = 8191;
            sl = (w_cur + ticks % SLOTS) % SLOTS;
            w_valid[id] = 1'b1; w_rot[id] = ROT_W'(rt); w_slot[id] = sl; w_tag[id] = tg;
            w_prev[id] = TIMERS; w_next[id] = w_head[sl];
            if (w_head[sl] < TIMERS) w_prev[w_head[sl]] = id;
            w_head[sl] = id;
            expected_results.push_back(mk(KIND_ADDED, id, 0, sl, rt, 1'b1));
        end else if (a == ACT_DEL) begin
            id = id_in;
            if (id >= TIMERS || !w_valid[id]) begin
                expected_results.push_back(mk(KIND_DEL_BAD, id, 0, 0, 0, 1'b1));
                return;
            end
            wheel_unlink(id);
            expected_results.push_back(mk(KIND_DELETED, id, 0, 0, 0, 1'b1));
        end else if (a == ACT_TICK) begin
            s = w_cur; cur = w_head[s]; steps = 0;
            while (cur < TIMERS && w_valid[cur] && steps < TIMERS) begin
                nx = w_next[cur];
                if (w_rot[cur] > 0) w_rot[cur]--;
                else begin
                    expected_results.push_back(mk(KIND_EXPIRED, cur, w_tag[cur], s, 0, 1'b0));
                    wheel_unlink(cur);
                end
                cur = nx; steps++;
            end
            expected_results.push_back(mk(KIND_TICKED, 0, 0, s, 0, 1'b1));
            w_cur = (s + 1) % SLOTS;
        end
    endfunction

    // result checker
    always @(posedge clk) begin
        t_res got, exp_r;
        if (rst_n && res_valid && !res_stall) begin
            got = {o_kind, o_id, o_tag, o_slot, o_rot, o_last};
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
            end else begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch: exp kind %0d id %0d tag %h slot %0d rot %0d last %0b",
                                 exp_r.kind, exp_r.id, exp_r.tag, exp_r.slot, exp_r.rot,
                                 exp_r.last);
                        $display("          got kind %0d id %0d tag %h slot %0d rot %0d last %0b",
                                 got.kind, got.id, got.tag, got.slot, got.rot, got.last);
                    end
                end
            end
        end
    end

    // receiver stall: long hold-off counted here, else random
    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            res_stall <= 1'b1;
        end else begin
            res_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    // valid stays high after an accepted item until the next idle cycle or drain
    task automatic send_item(logic [ACT_W-1:0] a, logic signed [TIME_W-1:0] t,
                             logic [ID_W-1:0] id, logic [TAG_W-1:0] tg);
        while ($urandom_range(99, 0) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1; act <= a; tmo <= t; tid <= id; utag <= tg;
        @(posedge clk);
        while (in_stall_out) @(posedge clk);
        wheel_predict(a, t, id, tg);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed();
        send_item(ACT_ADD, 20'sd0, 0, 16'hFFFF);           // zero timeout counts one tick
        send_item(ACT_ADD, 20'sd1, 0, 16'h0001);
        send_item(ACT_ADD, 20'sd64, 0, 16'h1234);          // current slot, one rotation
        send_item(ACT_ADD, 20'sd524287, 0, 16'hAAAA);      // largest timeout
        send_item(ACT_ADD, -20'sd1, 0, 16'h5555);          // negative rejected
        send_item(ACT_ADD, -20'sd524288, 0, 16'h0000);
        send_item(ACT_DEL, 0, 5'd31, 0);                   // unused id
        send_item(ACT_DEL, 0, 5'd3, 0);
        send_item(ACT_TICK, 0, 0, 0);
        send_item(ACT_TICK, 0, 0, 0);                      // expires zero and one
        send_item(ACT_NOP, 20'sd7, 5'd1, 16'h7777);         // ignored
        send_item(ACT_ADD, 20'sd63, 0, 16'h0BAD);
        for (int i = 0; i < 34; i++) send_item(ACT_ADD, 20'sd2, 0, 16'(i)); // pool full
        send_item(ACT_TICK, 0, 0, 0);
        send_item(ACT_TICK, 0, 0, 0);                      // empty slot; the filled slot is not reached
        for (int i = 0; i < TIMERS; i++) send_item(ACT_DEL, 0, ID_W'(i), 0);
        drain();
    endtask

    task automatic test_random(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99, 0);
            if (r < 40)
                send_item(ACT_ADD, (r < 3) ? -TIME_W'($urandom_range(524288, 1)) :
                          (r < 8) ? TIME_W'($urandom_range(524287, 0)) :
                          TIME_W'($urandom_range(8, 0)), 0, 16'($urandom));
            else if (r < 55) send_item(ACT_DEL, 0, 5'($urandom), 0);
            else if (r < 97) send_item(ACT_TICK, 0, 0, 0);
            else send_item(ACT_NOP, 20'($urandom), 5'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        for (int i = 0; i < 12; i++) send_item(ACT_ADD, TIME_W'(i % 3), 0, 16'($urandom));
        drain();
        repeat (60) @(posedge clk);  // sender pause after all results are back
        for (int i = 0; i < 6; i++) send_item(ACT_TICK, 0, 0, 0);
    endtask

    initial begin
        wheel_clear();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        idle_pct = 0;  stall_pct = 0;  test_random(70);
        idle_pct = 49; stall_pct = 0;  test_random(60);
        idle_pct = 0;  stall_pct = 49; test_random(60);
        idle_pct = 20; stall_pct = 20; test_random(60);
        idle_pct = 0;  stall_pct = 0;  test_backpressure();
        drain();
        stall_pct = 0;
        repeat (40) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("[timing_wheel_scheduler_core] OK");
        else
            $display("[timing_wheel_scheduler_core] ERROR");
        $finish;
    end

    initial begin
        #3ms;
        $display("[timing_wheel_scheduler_core] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
